>>> hw/rtl/bpm4_pkg.sv
// Shared types and constants for the four-antenna beam position monitor.
package bpm4_pkg;

    localparam int ADC_W       = 16;  // raw ADC field width
    localparam int PED_W       = 16;  // one pedestal
    localparam int CORR_W      = 17;  // signed reading after pedestal
    localparam int SUM_W       = 18;  // signed sum / difference of a pair
    localparam int MAG_W       = 18;  // magnitude of sum / difference
    localparam int CFG_W       = 32;
    localparam int POS_W       = 32;
    localparam int RATIO_OUT_W = 16;
    localparam int REG_IDX_W   = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PED_AB = 3'd0,
        REG_PED_CD = 3'd1,
        REG_COEF_XU = 3'd2,
        REG_COEF_XV = 3'd3,
        REG_COEF_YU = 3'd4,
        REG_COEF_YV = 3'd5,
        REG_OFFSET_X = 3'd6,
        REG_OFFSET_Y = 3'd7
    } t_reg_idx;

    localparam logic [CFG_W-1:0] COEF_ONE = 32'h0001_0000;  // 1.0 in Q16.16

    // rotation / offset settings seen by the merge stage
    typedef struct packed {
        logic signed [POS_W-1:0] xu;
        logic signed [POS_W-1:0] xv;
        logic signed [POS_W-1:0] yu;
        logic signed [POS_W-1:0] yv;
        logic signed [POS_W-1:0] off_x;
        logic signed [POS_W-1:0] off_y;
    } t_coef;

    // per-item flags riding along the divider
    typedef struct packed {
        logic neg;   // quotient sign
        logic zero;  // corrected sum is zero
        logic ovf;   // |diff| >= 2|sum|, quotient saturates
    } t_div_flags;

endpackage

>>> hw/rtl/bpm4_div_stage.sv
// One quotient-bit step of the pipelined restoring divider.
module bpm4_div_stage
    import bpm4_pkg::*;
#(
    parameter int QUO_W = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [MAG_W:0]     i_rem,
    input  logic [MAG_W-1:0]   i_den,
    input  logic [QUO_W-1:0]   i_quo,
    input  t_div_flags         i_flags,
    output logic [MAG_W:0]     o_rem,
    output logic [MAG_W-1:0]   o_den,
    output logic [QUO_W-1:0]   o_quo,
    output t_div_flags         o_flags
);

    logic           w_ge;
    logic [MAG_W:0] w_rem;

    // remainder enters below 2*den, so after the subtract it is below den and leaves shifted, still below 2*den
    assign w_ge  = i_rem >= {1'b0, i_den};
    assign w_rem = w_ge ? (i_rem - {1'b0, i_den}) : i_rem;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem   <= {w_rem[MAG_W-1:0], 1'b0};
            o_den   <= i_den;
            o_quo   <= {i_quo[QUO_W-2:0], w_ge};
            o_flags <= i_flags;
        end
    end

endmodule

>>> hw/rtl/bpm4_ratio_lane.sv
// One antenna pair: pedestal, sum/difference, pipelined divide, saturation.
module bpm4_ratio_lane
    import bpm4_pkg::*;
#(
    parameter int ADC_BITS        = 16,
    parameter int RATIO_FRAC_BITS = 15
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic [ADC_W-1:0]                  i_adc_a,
    input  logic [ADC_W-1:0]                  i_adc_b,
    input  logic [PED_W-1:0]                  i_ped_a,
    input  logic [PED_W-1:0]                  i_ped_b,
    output logic signed [RATIO_FRAC_BITS:0]   o_ratio,
    output logic                              o_zero
);

    localparam int QUO_W   = RATIO_FRAC_BITS + 1;
    localparam int ADC_USE = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
    localparam logic [QUO_W-1:0] RATIO_MAX = {1'b0, {RATIO_FRAC_BITS{1'b1}}};
    localparam logic [QUO_W-1:0] RATIO_MIN = {1'b1, {RATIO_FRAC_BITS{1'b0}}};

    logic [ADC_W-1:0]         w_adc_a;
    logic [ADC_W-1:0]         w_adc_b;
    logic signed [CORR_W-1:0] w_corr_a;
    logic signed [CORR_W-1:0] w_corr_b;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  r_diff;
    logic [MAG_W-1:0]         w_mag_sum;
    logic [MAG_W-1:0]         w_mag_diff;

    logic [MAG_W:0]     r_rem0;
    logic [MAG_W-1:0]   r_den0;
    t_div_flags         r_flg0;

    logic [MAG_W:0]     w_rem [0:QUO_W];
    logic [MAG_W-1:0]   w_den [0:QUO_W];
    logic [QUO_W-1:0]   w_quo [0:QUO_W];
    t_div_flags         w_flg [0:QUO_W];

    logic [QUO_W-1:0]   w_q;
    logic               w_big_pos;
    logic               w_big_neg;
    logic [QUO_W-1:0]   n_ratio;

    // stage A: drop unused ADC bits, remove pedestals, form sum and difference
    assign w_adc_a  = ADC_W'(i_adc_a[ADC_USE-1:0]);
    assign w_adc_b  = ADC_W'(i_adc_b[ADC_USE-1:0]);
    assign w_corr_a = $signed({1'b0, w_adc_a}) - $signed({1'b0, i_ped_a});
    assign w_corr_b = $signed({1'b0, w_adc_b}) - $signed({1'b0, i_ped_b});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum  <= SUM_W'(w_corr_a) + SUM_W'(w_corr_b);
            r_diff <= SUM_W'(w_corr_a) - SUM_W'(w_corr_b);
        end
    end

    // stage B: magnitudes, sign, zero and out-of-range checks
    assign w_mag_sum  = MAG_W'(r_sum[SUM_W-1] ? -r_sum : r_sum);
    assign w_mag_diff = MAG_W'(r_diff[SUM_W-1] ? -r_diff : r_diff);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem0      <= {1'b0, w_mag_diff};
            r_den0      <= w_mag_sum;
            r_flg0.neg  <= r_sum[SUM_W-1] ^ r_diff[SUM_W-1];
            r_flg0.zero <= (r_sum == '0);
            r_flg0.ovf  <= {1'b0, w_mag_diff} >= {w_mag_sum, 1'b0};
        end
    end

    assign w_rem[0] = r_rem0;
    assign w_den[0] = r_den0;
    assign w_quo[0] = '0;
    assign w_flg[0] = r_flg0;

    // one quotient bit per stage, MSB first
    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        bpm4_div_stage #(
            .QUO_W(QUO_W)
        ) u_stage (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_rem  (w_rem[k]),
            .i_den  (w_den[k]),
            .i_quo  (w_quo[k]),
            .i_flags(w_flg[k]),
            .o_rem  (w_rem[k+1]),
            .o_den  (w_den[k+1]),
            .o_quo  (w_quo[k+1]),
            .o_flags(w_flg[k+1])
        );
    end

    // final stage: apply sign, clamp to [-1, 1)
    assign w_q       = w_quo[QUO_W];
    assign w_big_pos = w_flg[QUO_W].ovf || w_q[RATIO_FRAC_BITS];
    assign w_big_neg = w_flg[QUO_W].ovf ||
                       (w_q[RATIO_FRAC_BITS] && (|w_q[RATIO_FRAC_BITS-1:0]));

    always_comb begin
        priority if (w_flg[QUO_W].zero) begin
            n_ratio = '0;
        end else if (w_flg[QUO_W].neg) begin
            n_ratio = w_big_neg ? RATIO_MIN : (QUO_W'(0) - w_q);
        end else begin
            n_ratio = w_big_pos ? RATIO_MAX : w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ratio <= $signed(n_ratio);
            o_zero  <= w_flg[QUO_W].zero;
        end
    end

endmodule

>>> hw/rtl/bpm4_position.sv
// Merge stage: rotate (u, v) into (x, y), round, add offsets, saturate.
module bpm4_position
    import bpm4_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = 15
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  t_coef                            i_coef,
    input  logic signed [RATIO_FRAC_BITS:0]  i_u,
    input  logic signed [RATIO_FRAC_BITS:0]  i_v,
    input  logic                             i_zero_u,
    input  logic                             i_zero_v,
    output logic [RATIO_OUT_W-1:0]           o_ratio_u,
    output logic [RATIO_OUT_W-1:0]           o_ratio_v,
    output logic signed [POS_W-1:0]          o_beam_x,
    output logic signed [POS_W-1:0]          o_beam_y,
    output logic                             o_zero_u,
    output logic                             o_zero_v
);

    localparam int RATIO_W = RATIO_FRAC_BITS + 1;
    localparam int PROD_W  = POS_W + RATIO_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int RND_W   = ACC_W - RATIO_FRAC_BITS;
    localparam int OFS_W   = RND_W + 1;
    localparam int DLY     = 3;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1 << (RATIO_FRAC_BITS - 1));
    localparam logic signed [OFS_W-1:0] POS_MAX = OFS_W'(64'sh7FFF_FFFF);
    localparam logic signed [OFS_W-1:0] POS_MIN = -OFS_W'(64'sh7FFF_FFFF) - OFS_W'(1);

    logic signed [PROD_W-1:0] r_pxu, r_pxv, r_pyu, r_pyv;
    logic signed [ACC_W-1:0]  r_sx, r_sy;
    logic signed [ACC_W-1:0]  w_tx, w_ty;
    logic signed [RND_W-1:0]  r_rx, r_ry;
    logic signed [OFS_W-1:0]  w_ox, w_oy;
    logic signed [POS_W-1:0]  n_beam_x, n_beam_y;

    // ratios and flags ride along the first three stages
    logic signed [RATIO_W-1:0] r_u_dly [0:DLY-1];
    logic signed [RATIO_W-1:0] r_v_dly [0:DLY-1];
    logic [1:0]                r_z_dly [0:DLY-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u_dly[0] <= i_u;
            r_v_dly[0] <= i_v;
            r_z_dly[0] <= {i_zero_v, i_zero_u};
            for (int i = 1; i < DLY; i++) begin
                r_u_dly[i] <= r_u_dly[i-1];
                r_v_dly[i] <= r_v_dly[i-1];
                r_z_dly[i] <= r_z_dly[i-1];
            end
        end
    end

    // stage 1: four products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pxu <= PROD_W'(i_coef.xu) * PROD_W'(i_u);
            r_pxv <= PROD_W'(i_coef.xv) * PROD_W'(i_v);
            r_pyu <= PROD_W'(i_coef.yu) * PROD_W'(i_u);
            r_pyv <= PROD_W'(i_coef.yv) * PROD_W'(i_v);
        end
    end

    // stage 2: exact sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= ACC_W'(r_pxu) + ACC_W'(r_pxv);
            r_sy <= ACC_W'(r_pyu) + ACC_W'(r_pyv);
        end
    end

    // stage 3: round half up, drop fraction bits
    assign w_tx = r_sx + HALF;
    assign w_ty = r_sy + HALF;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx <= w_tx[ACC_W-1:RATIO_FRAC_BITS];
            r_ry <= w_ty[ACC_W-1:RATIO_FRAC_BITS];
        end
    end

    // stage 4: offset and clamp into the output register
    assign w_ox = OFS_W'(r_rx) + OFS_W'(i_coef.off_x);
    assign w_oy = OFS_W'(r_ry) + OFS_W'(i_coef.off_y);

    always_comb begin
        priority if (w_ox > POS_MAX) begin
            n_beam_x = POS_W'(POS_MAX);
        end else if (w_ox < POS_MIN) begin
            n_beam_x = POS_W'(POS_MIN);
        end else begin
            n_beam_x = POS_W'(w_ox);
        end
        priority if (w_oy > POS_MAX) begin
            n_beam_y = POS_W'(POS_MAX);
        end else if (w_oy < POS_MIN) begin
            n_beam_y = POS_W'(POS_MIN);
        end else begin
            n_beam_y = POS_W'(w_oy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_beam_x  <= n_beam_x;
            o_beam_y  <= n_beam_y;
            o_ratio_u <= RATIO_OUT_W'(r_u_dly[DLY-1]);
            o_ratio_v <= RATIO_OUT_W'(r_v_dly[DLY-1]);
            o_zero_u  <= r_z_dly[DLY-1][0];
            o_zero_v  <= r_z_dly[DLY-1][1];
        end
    end

endmodule

>>> hw/rtl/bpm_four_antenna_position.sv
// Throughput: one item per clock; the pipeline stalls as a whole only while a
// finished result sits in the output register and the sink holds tready low.
// The depth is set by the dividers, one quotient bit per stage in each lane.
// Reset (synchronous, active low) empties the pipeline and loads register defaults;
// data registers inside the pipeline are not reset.
module bpm_four_antenna_position
    import bpm4_pkg::*;
#(
    parameter int ADC_BITS        = 16,
    parameter int RATIO_FRAC_BITS = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [REG_IDX_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_wdata,

    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [15:0] adc_one, [31:16] adc_two, [47:32] adc_three, [63:48] adc_four
    input  logic [4*ADC_W-1:0]    i_s_axis_tdata,

    // output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [15:0] ratio_u, [31:16] ratio_v, [63:32] beam_x, [95:64] beam_y
    output logic [2*RATIO_OUT_W+2*POS_W-1:0] o_m_axis_tdata,
    // [0] zero_sum_u, [1] zero_sum_v
    output logic [1:0]            o_m_axis_tuser
);

    // lane: 2 front stages + (RATIO_FRAC_BITS+1) divide stages + clamp;
    // merge: multiply, sum, round, offset/output register
    localparam int LAT = RATIO_FRAC_BITS + 8;

    logic                          w_adv;
    logic [LAT-1:0]                r_vld;

    // configuration registers
    logic [CFG_W-1:0]              r_ped_ab;
    logic [CFG_W-1:0]              r_ped_cd;
    t_coef                         r_coef;

    logic signed [RATIO_FRAC_BITS:0] w_u, w_v;
    logic                          w_zero_u, w_zero_v;
    logic [RATIO_OUT_W-1:0]        w_ratio_u, w_ratio_v;
    logic signed [POS_W-1:0]       w_beam_x, w_beam_y;
    logic                          w_zs_u, w_zs_v;

    // Host writes to these must come only while the pipeline is empty; the block does
    // not enforce this. Lane stage A and merge stages 1 and 4 read them directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ped_ab     <= '0;
            r_ped_cd     <= '0;
            r_coef.xu    <= $signed(COEF_ONE);
            r_coef.xv    <= '0;
            r_coef.yu    <= '0;
            r_coef.yv    <= $signed(COEF_ONE);
            r_coef.off_x <= '0;
            r_coef.off_y <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_PED_AB:   r_ped_ab     <= i_cfg_wdata;
                REG_PED_CD:   r_ped_cd     <= i_cfg_wdata;
                REG_COEF_XU:  r_coef.xu    <= $signed(i_cfg_wdata);
                REG_COEF_XV:  r_coef.xv    <= $signed(i_cfg_wdata);
                REG_COEF_YU:  r_coef.yu    <= $signed(i_cfg_wdata);
                REG_COEF_YV:  r_coef.yv    <= $signed(i_cfg_wdata);
                REG_OFFSET_X: r_coef.off_x <= $signed(i_cfg_wdata);
                REG_OFFSET_Y: r_coef.off_y <= $signed(i_cfg_wdata);
            endcase
        end
    end

    // Whole pipeline moves when the output register is empty or being drained.
    // A bubble entering shifts in as an invalid slot.
    assign w_adv           = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    // lane u: antennas one and two
    bpm4_ratio_lane #(
        .ADC_BITS       (ADC_BITS),
        .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
    ) u_lane_u (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_adc_a(i_s_axis_tdata[ADC_W-1:0]),
        .i_adc_b(i_s_axis_tdata[2*ADC_W-1:ADC_W]),
        .i_ped_a(r_ped_ab[PED_W-1:0]),
        .i_ped_b(r_ped_ab[2*PED_W-1:PED_W]),
        .o_ratio(w_u),
        .o_zero (w_zero_u)
    );

    // lane v: antennas three and four
    bpm4_ratio_lane #(
        .ADC_BITS       (ADC_BITS),
        .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
    ) u_lane_v (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_adc_a(i_s_axis_tdata[3*ADC_W-1:2*ADC_W]),
        .i_adc_b(i_s_axis_tdata[4*ADC_W-1:3*ADC_W]),
        .i_ped_a(r_ped_cd[PED_W-1:0]),
        .i_ped_b(r_ped_cd[2*PED_W-1:PED_W]),
        .o_ratio(w_v),
        .o_zero (w_zero_v)
    );

    // merge both lanes into the beam position; ends in the output register
    bpm4_position #(
        .RATIO_FRAC_BITS(RATIO_FRAC_BITS)
    ) u_position (
        .i_clk    (i_clk),
        .i_en     (w_adv),
        .i_coef   (r_coef),
        .i_u      (w_u),
        .i_v      (w_v),
        .i_zero_u (w_zero_u),
        .i_zero_v (w_zero_v),
        .o_ratio_u(w_ratio_u),
        .o_ratio_v(w_ratio_v),
        .o_beam_x (w_beam_x),
        .o_beam_y (w_beam_y),
        .o_zero_u (w_zs_u),
        .o_zero_v (w_zs_v)
    );

    assign o_m_axis_tdata = {w_beam_y, w_beam_x, w_ratio_v, w_ratio_u};
    assign o_m_axis_tuser = {w_zs_v, w_zs_u};

endmodule
